// ===== hw/rtl/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam int MaxBytes = 9;
  localparam int CpBytes  = 6;
  localparam int CntW     = $clog2(MaxBytes + 1);

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;

  localparam logic [39:0] EntAmp  = "&amp;";
  localparam logic [31:0] EntLt   = "&lt;";
  localparam logic [31:0] EntGt   = "&gt;";
  localparam logic [47:0] EntQuot = "&quot;";

  localparam logic REG_BYTE_MODE = 1'b0;
  localparam logic REG_ESCAPE    = 1'b1;

  typedef logic [7:0] byte_t;
  typedef byte_t [MaxBytes-1:0] byte_vec_t;

  typedef struct packed {
    byte_t [CpBytes-1:0] b;
    logic [2:0]          n;
  } cp_enc_t;

  typedef struct packed {
    byte_vec_t       bytes;
    logic [CntW-1:0] count;
  } burst_t;

  typedef struct packed {
    burst_t      burst;
    logic        hold;
    logic [9:0]  hold_bits;
  } enc_res_t;

  // utf-8 bytes of one code point, with xml entities for the four specials
  function automatic cp_enc_t enc_cp(input logic [20:0] cp, input logic esc);
    cp_enc_t r;
    r.b = '0;
    r.n = 3'd1;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      if (esc) begin
        case (cp[7:0])
          8'h26: begin
            r.b[0] = EntAmp[39:32]; r.b[1] = EntAmp[31:24]; r.b[2] = EntAmp[23:16];
            r.b[3] = EntAmp[15:8];  r.b[4] = EntAmp[7:0];   r.n = 3'd5;
          end
          8'h3C: begin
            r.b[0] = EntLt[31:24]; r.b[1] = EntLt[23:16];
            r.b[2] = EntLt[15:8];  r.b[3] = EntLt[7:0];   r.n = 3'd4;
          end
          8'h3E: begin
            r.b[0] = EntGt[31:24]; r.b[1] = EntGt[23:16];
            r.b[2] = EntGt[15:8];  r.b[3] = EntGt[7:0];   r.n = 3'd4;
          end
          8'h22: begin
            r.b[0] = EntQuot[47:40]; r.b[1] = EntQuot[39:32]; r.b[2] = EntQuot[31:24];
            r.b[3] = EntQuot[23:16]; r.b[4] = EntQuot[15:8];  r.b[5] = EntQuot[7:0];
            r.n = 3'd6;
          end
          default: r.n = 3'd1;
        endcase
      end
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.n = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/u16u8_enc.sv =====
module u16u8_enc (
  input  logic [15:0]        code_unit,
  input  logic               last_unit,
  input  logic               held_valid,
  input  logic [9:0]         held_bits,
  input  logic               byte_mode,
  input  logic               escape_enable,
  output u16u8_pkg::enc_res_t res
);

  logic                is_high;
  logic                is_low;
  logic                flush;
  logic                emit;
  logic [20:0]         cp;
  logic                hold;
  logic [9:0]          hold_bits;
  u16u8_pkg::burst_t   burst;
  u16u8_pkg::cp_enc_t  flush_enc;
  u16u8_pkg::cp_enc_t  unit_enc;

  assign is_high = (code_unit >= u16u8_pkg::HighFirst) && (code_unit <= u16u8_pkg::HighLast);
  assign is_low  = (code_unit >= u16u8_pkg::LowFirst) && (code_unit <= u16u8_pkg::LowLast);

  always_comb begin
    flush     = held_valid;
    emit      = 1'b1;
    cp        = {5'd0, code_unit};
    hold      = 1'b0;
    hold_bits = '0;
    if (byte_mode) begin
      cp = {13'd0, code_unit[7:0]};
    end else if (held_valid && is_low) begin
      // surrogate pair
      flush = 1'b0;
      cp    = u16u8_pkg::SuppBase + {1'b0, held_bits, code_unit[9:0]};
    end else if (is_high && !last_unit) begin
      emit      = 1'b0;
      hold      = 1'b1;
      hold_bits = code_unit[9:0];
    end
  end

  assign flush_enc = u16u8_pkg::enc_cp({5'd0, 6'b110110, held_bits}, escape_enable);
  assign unit_enc  = u16u8_pkg::enc_cp(cp, escape_enable);

  always_comb begin
    burst.bytes = '0;
    burst.count = '0;
    if (flush) begin
      burst.bytes[2:0] = flush_enc.b[2:0];
      burst.count      = u16u8_pkg::CntW'(3);
      if (emit) begin
        burst.bytes[8:3] = unit_enc.b;
        burst.count      = u16u8_pkg::CntW'(3) + u16u8_pkg::CntW'(unit_enc.n);
      end
    end else if (emit) begin
      burst.bytes[5:0] = unit_enc.b;
      burst.count      = u16u8_pkg::CntW'(unit_enc.n);
    end
  end

  assign res = '{burst: burst, hold: hold, hold_bits: hold_bits};

endmodule

// ===== hw/rtl/u16u8_ser.sv =====
module u16u8_ser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  u16u8_pkg::burst_t   burst,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_run_last
);

  u16u8_pkg::byte_vec_t        bytes_r;
  logic [u16u8_pkg::CntW-1:0]  cnt_r;
  logic [u16u8_pkg::CntW-1:0]  idx_r;
  logic [u16u8_pkg::CntW-1:0]  idx_nxt;
  logic                        valid_r;
  logic                        valid_nxt;

  assign out_valid    = valid_r;
  assign out_byte     = bytes_r[idx_r];
  assign out_run_last = (idx_r == cnt_r - u16u8_pkg::CntW'(1));
  assign free         = !valid_r || (out_ready && out_run_last);

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (valid_r && out_ready) begin
      if (out_run_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + u16u8_pkg::CntW'(1);
      end
    end
    if (load) begin
      idx_nxt   = '0;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= burst.bytes;
      cnt_r   <= burst.count;
    end
  end

endmodule

// ===== hw/rtl/utf16_to_utf8_escaping_encoder_top.sv =====
// utf-16le (or latin-1) to utf-8 transcoder with optional xml escaping
//
// input channel: in_code_unit, in_last_unit under in_valid/in_ready; one
// string code unit per transfer, in_last_unit high on the final unit.
// output channel: out_byte, out_run_last under out_valid/out_ready; one
// utf-8 byte per transfer, out_run_last high on the last byte of a unit.
// config: apb-style, byte_mode at 0x0, escape_enable at 0x4, write only
// while idle. pready is tied high.
// path: a unit passes the input register and the combinational encoder
// into the byte buffer. throughput: one output byte per cycle while
// out_ready is high; a unit yields 1 to 6 bytes, 3 more when a held
// surrogate is flushed, and a held high surrogate yields nothing and
// passes without the buffer. the output byte buffer is the limit.
// reset clears the registers, the held surrogate and both pipeline stages.
// when out_ready is low the byte buffer holds; one more unit with bytes
// enters the input register, then in_ready drops until the buffer drains.
module utf16_to_utf8_escaping_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 unit_valid_r;
  logic [15:0]          unit_r;
  logic                 last_r;
  logic                 held_valid_r;
  logic [9:0]           held_bits_r;
  logic                 byte_mode_r;
  logic                 escape_r;
  logic                 move;
  logic                 load;
  logic                 ser_free;
  logic                 cfg_wr;
  u16u8_pkg::enc_res_t  enc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      u16u8_pkg::REG_BYTE_MODE: prdata = {31'd0, byte_mode_r};
      u16u8_pkg::REG_ESCAPE:    prdata = {31'd0, escape_r};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_r <= 1'b0;
      escape_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        u16u8_pkg::REG_BYTE_MODE: byte_mode_r <= pwdata[0];
        u16u8_pkg::REG_ESCAPE:    escape_r    <= pwdata[0];
        default:                  byte_mode_r <= byte_mode_r;
      endcase
    end
  end

  u16u8_enc u_enc (
    .code_unit     (unit_r),
    .last_unit     (last_r),
    .held_valid    (held_valid_r),
    .held_bits     (held_bits_r),
    .byte_mode     (byte_mode_r),
    .escape_enable (escape_r),
    .res           (enc)
  );

  // units that yield nothing pass without the byte buffer
  assign move     = unit_valid_r && ((enc.burst.count == '0) || ser_free);
  assign load     = move && (enc.burst.count != '0);
  assign in_ready = !unit_valid_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_valid_r <= 1'b0;
      held_valid_r <= 1'b0;
      held_bits_r  <= '0;
    end else begin
      if (in_ready) begin
        unit_valid_r <= in_valid;
      end
      if (move) begin
        held_valid_r <= enc.hold;
        held_bits_r  <= enc.hold_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      unit_r <= in_code_unit;
      last_r <= in_last_unit;
    end
  end

  u16u8_ser u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .burst        (enc.burst),
    .free         (ser_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  a_byte_mode_drops_hold: assert property (@(posedge clk) disable iff (!rst_n)
    move && byte_mode_r |=> !held_valid_r)
    else $error("surrogate still held after a byte-mode unit");

  a_no_hold_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    move && enc.hold |-> !last_r)
    else $error("final unit of a string was held");

  a_load_shows_byte: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded burst not offered");

  a_stalled_unit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    unit_valid_r && !move |=> unit_valid_r && $stable(unit_r) && $stable(last_r))
    else $error("pending unit lost while the buffer was busy");

endmodule
